### rtl/rau_pkg.sv
// Package: shared constants, codes and field layout for the rational arithmetic unit.
package rau_pkg;

    localparam int OperandWidth = 16;
    localparam int DenWidth     = OperandWidth - 1;
    localparam int ProdWidth    = 2 * OperandWidth + 1;
    localparam int MagWidth     = 2 * OperandWidth;
    localparam int CntWidth     = $clog2(MagWidth + 1);

    localparam int OutNumWidth  = 32;
    localparam int OutDenWidth  = 31;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_CMP = 3'd4;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    localparam int InBits   = 3 + 2 * OperandWidth + 2 * DenWidth;
    localparam int InBytes  = (InBits + 7) / 8;
    localparam int OutBits  = OutNumWidth + OutDenWidth + 2 + 1;
    localparam int OutBytes = (OutBits + 7) / 8;

    typedef logic [MagWidth-1:0] mag_t;

    // Request from the sequencer to the shared divide unit.
    typedef struct packed {
        logic start;
        mag_t dividend;
        mag_t divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        mag_t quotient;
        mag_t remainder;
    } div_rsp_t;

endpackage

### rtl/rau_divider.sv
// Shared restoring divider: one quotient bit per cycle.
module rau_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    logic                busy_reg;
    logic [CntWidth-1:0] cnt_reg;
    mag_t                quo_reg;
    mag_t                rem_reg;
    mag_t                dsr_reg;
    logic                done_reg;
    logic [MagWidth:0]   trial;
    mag_t                shifted;

    always_comb
    begin
        shifted = {rem_reg[MagWidth-2:0], quo_reg[MagWidth-1]};
        trial   = {rem_reg[MagWidth-1], shifted} - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntWidth'(MagWidth);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CntWidth'(1);
                if (cnt_reg == CntWidth'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[MagWidth])
            begin
                rem_reg <= trial[MagWidth-1:0];
                quo_reg <= {quo_reg[MagWidth-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[MagWidth-2:0], 1'b0};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/rau_core.sv
// Sequencer: cross products, Euclid GCD on the shared divider, final reduction.
module rau_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [2:0]                          action,
    input  logic signed [rau_pkg::OperandWidth-1:0] left_num,
    input  logic [rau_pkg::DenWidth-1:0]        left_den,
    input  logic signed [rau_pkg::OperandWidth-1:0] right_num,
    input  logic [rau_pkg::DenWidth-1:0]        right_den,
    output logic                                done,
    output logic signed [rau_pkg::OutNumWidth-1:0] result_num,
    output logic [rau_pkg::OutDenWidth-1:0]     result_den,
    output logic [1:0]                          order,
    output logic                                div_by_zero,
    output rau_pkg::div_req_t                   dreq,
    input  rau_pkg::div_rsp_t                   drsp
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_FORM = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_QNUM = 4'd6;
    localparam logic [3:0] S_QDEN = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg;
    logic       wait_reg;
    logic [2:0] act_reg;
    logic signed [OperandWidth:0] ln_reg, ld_reg, rn_reg, rd_reg;
    logic signed [OperandWidth:0] ma_reg, mb_reg;
    logic signed [ProdWidth-1:0]  p0_reg, p1_reg, p2_reg;
    logic signed [ProdWidth-1:0]  prod;
    logic signed [ProdWidth:0]    sum;
    logic       neg_reg;
    mag_t       mag_reg, den_reg, ga_reg, gb_reg, g_reg;
    logic signed [OutNumWidth-1:0] rnum_reg;
    logic [OutDenWidth-1:0]        rden_reg;
    logic [1:0] ord_reg;
    logic       dz_reg;
    logic       done_reg;
    logic       dstart;
    mag_t       dvd, dvs;
    logic signed [ProdWidth:0] nfull, dfull;

    assign prod = ProdWidth'(ma_reg * mb_reg);

    always_comb
    begin
        sum = '0;
        case (act_reg)
            ACT_SUB: sum = {p0_reg[ProdWidth-1], p0_reg} - {p1_reg[ProdWidth-1], p1_reg};
            default: sum = {p0_reg[ProdWidth-1], p0_reg} + {p1_reg[ProdWidth-1], p1_reg};
        endcase
    end

    always_comb
    begin
        dvd = ga_reg;
        dvs = gb_reg;
        if (state_reg == S_QNUM)
        begin
            dvd = mag_reg;
            dvs = g_reg;
        end
        else if (state_reg == S_QDEN)
        begin
            dvd = den_reg;
            dvs = g_reg;
        end
    end

    assign dreq.start    = dstart;
    assign dreq.dividend = dvd;
    assign dreq.divisor  = dvs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1: state_reg <= S_MUL2;
                S_MUL2: state_reg <= S_MUL3;
                S_MUL3: state_reg <= S_FORM;
                S_FORM:
                begin
                    if (act_reg == ACT_ADD || act_reg == ACT_SUB || act_reg == ACT_MUL
                        || (act_reg == ACT_DIV && rn_reg != 0))
                    begin
                        state_reg <= S_GCD;
                        wait_reg  <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_GCD:
                begin
                    if (!wait_reg)
                    begin
                        if (gb_reg == '0)
                        begin
                            state_reg <= S_QNUM;
                        end
                        else
                        begin
                            wait_reg <= 1'b1;
                        end
                    end
                    else if (drsp.done)
                    begin
                        wait_reg <= 1'b0;
                    end
                end
                S_QNUM:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (drsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        state_reg <= S_QDEN;
                    end
                end
                S_QDEN:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (drsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign dstart = !wait_reg && ((state_reg == S_GCD && gb_reg != '0)
                    || state_reg == S_QNUM || state_reg == S_QDEN);

    always_comb
    begin
        nfull = sum;
        dfull = {p1_reg[ProdWidth-1], p1_reg};
        if (act_reg == ACT_ADD || act_reg == ACT_SUB)
        begin
            dfull = {p2_reg[ProdWidth-1], p2_reg};
        end
        else if (act_reg == ACT_MUL)
        begin
            nfull = {p0_reg[ProdWidth-1], p0_reg};
        end
        else if (act_reg == ACT_DIV)
        begin
            nfull = {p0_reg[ProdWidth-1], p0_reg};
            if (p1_reg < 0)
            begin
                nfull = -{p0_reg[ProdWidth-1], p0_reg};
                dfull = -{p1_reg[ProdWidth-1], p1_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_reg <= action;
                    ln_reg  <= {left_num[OperandWidth-1], left_num};
                    rn_reg  <= {right_num[OperandWidth-1], right_num};
                    ld_reg  <= (left_den == '0) ? (OperandWidth+1)'(1)
                                                : {2'b00, left_den};
                    rd_reg  <= (right_den == '0) ? (OperandWidth+1)'(1)
                                                 : {2'b00, right_den};
                    ma_reg  <= {left_num[OperandWidth-1], left_num};
                    mb_reg  <= (right_den == '0) ? (OperandWidth+1)'(1)
                                                 : {2'b00, right_den};
                    if (action == ACT_MUL)
                    begin
                        mb_reg <= {right_num[OperandWidth-1], right_num};
                    end
                end
            end
            S_MUL1:
            begin
                // first product: numerator term; set up the second
                p0_reg <= prod;
                if (act_reg == ACT_ADD || act_reg == ACT_SUB || act_reg == ACT_CMP)
                begin
                    ma_reg <= rn_reg;
                    mb_reg <= ld_reg;
                end
                else if (act_reg == ACT_DIV)
                begin
                    ma_reg <= ld_reg;
                    mb_reg <= rn_reg;
                end
                else
                begin
                    ma_reg <= ld_reg;
                    mb_reg <= rd_reg;
                end
            end
            S_MUL2:
            begin
                // second product; set up the third, the common denominator for add and subtract
                p1_reg <= prod;
                ma_reg <= ld_reg;
                mb_reg <= rd_reg;
            end
            S_MUL3: p2_reg <= prod;
            S_FORM:
            begin
                rnum_reg <= '0;
                rden_reg <= OutDenWidth'(1);
                ord_reg  <= ORD_EQUAL;
                dz_reg   <= 1'b0;
                neg_reg  <= nfull < 0;
                mag_reg  <= (nfull < 0) ? MagWidth'(-nfull) : MagWidth'(nfull);
                den_reg  <= MagWidth'(dfull);
                ga_reg   <= (nfull < 0) ? MagWidth'(-nfull) : MagWidth'(nfull);
                gb_reg   <= MagWidth'(dfull);
                if (act_reg == ACT_CMP)
                begin
                    if (p0_reg < p1_reg)
                    begin
                        ord_reg <= ORD_LESS;
                    end
                    else if (p0_reg > p1_reg)
                    begin
                        ord_reg <= ORD_GREATER;
                    end
                end
                if (act_reg == ACT_DIV && rn_reg == 0)
                begin
                    dz_reg <= 1'b1;
                end
            end
            S_GCD:
            begin
                if (!wait_reg && gb_reg == '0)
                begin
                    // gcd(a, 0) = a: the Euclid loop has ended and ga holds the gcd
                    g_reg <= ga_reg;
                end
                else if (wait_reg && drsp.done)
                begin
                    ga_reg <= gb_reg;
                    gb_reg <= drsp.remainder;
                end
            end
            S_QNUM:
            begin
                if (wait_reg && drsp.done)
                begin
                    rnum_reg <= neg_reg ? -OutNumWidth'(drsp.quotient)
                                        : OutNumWidth'(drsp.quotient);
                end
            end
            S_QDEN:
            begin
                if (wait_reg && drsp.done)
                begin
                    rden_reg <= OutDenWidth'(drsp.quotient);
                end
            end
            default: ;
        endcase
    end

    assign done        = done_reg;
    assign result_num  = rnum_reg;
    assign result_den  = rden_reg;
    assign order       = ord_reg;
    assign div_by_zero = dz_reg;

endmodule

### rtl/rational_arithmetic_unit.sv
// Top level: stream wrapper around the rational arithmetic sequencer and divider.
//  channel | dir | fields (tdata lsb up)
//  s_axis  | in  | action, left_num, left_den, right_num, right_den
//  m_axis  | out | result_num, result_den, order, div_by_zero
// One item at a time; each division on the shared 32-step divider runs start,
// 32 steps, done. Add, subtract, multiply and divide run one division per Euclid
// step plus two for the final reduction; compare, a zero divisor or an unknown
// code skip the divider.
// Reset is asynchronous, active low; a result waits in the output register
// until taken, and the block takes a new item only once it has gone out.
module rational_arithmetic_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // action, left_num, left_den, right_num, right_den
    input  logic [8*rau_pkg::InBytes-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_num, result_den, order, div_by_zero
    output logic [8*rau_pkg::OutBytes-1:0]   m_axis_tdata
);
    import rau_pkg::*;

    logic busy_reg;
    logic ovalid_reg;
    logic start;
    logic done;
    div_req_t dreq;
    div_rsp_t drsp;
    logic signed [OutNumWidth-1:0] result_num;
    logic [OutDenWidth-1:0] result_den;
    logic [1:0] order;
    logic div_by_zero;

    localparam int LnLo = 3;
    localparam int LdLo = LnLo + OperandWidth;
    localparam int RnLo = LdLo + DenWidth;
    localparam int RdLo = RnLo + OperandWidth;

    assign s_axis_tready = !busy_reg && !ovalid_reg;
    assign start = s_axis_tvalid && s_axis_tready;

    rau_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (s_axis_tdata[2:0]),
        .left_num   (s_axis_tdata[LdLo-1:LnLo]),
        .left_den   (s_axis_tdata[RnLo-1:LdLo]),
        .right_num  (s_axis_tdata[RdLo-1:RnLo]),
        .right_den  (s_axis_tdata[InBits-1:RdLo]),
        .done       (done),
        .result_num (result_num),
        .result_den (result_den),
        .order      (order),
        .div_by_zero(div_by_zero),
        .dreq       (dreq),
        .drsp       (drsp)
    );

    rau_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg   <= 1'b0;
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(8*OutBytes-OutBits){1'b0}},
                            div_by_zero, order, result_den, result_num};

endmodule

### rtl/rau_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top level.
module rau_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [8*rau_pkg::OutBytes-1:0] m_axis_tdata
);
    import rau_pkg::*;

    // no new item while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // an accepted item makes the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after accept");

    // a result holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // denominator never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OutNumWidth+OutDenWidth-1:OutNumWidth] != '0)
        else $error("zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

### test/rau_checker.sv
// Checker: watches both stream channels, predicts each result and compares it.
`timescale 1ns / 100ps
module rau_scoreboard (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [8*rau_pkg::InBytes-1:0]     s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [8*rau_pkg::OutBytes-1:0]    m_axis_tdata,
    output int                                fail_count,
    output int                                pending,
    output int                                checked
);
    import rau_pkg::*;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  ord;
        logic        dz;
    } frac_res_t;

    frac_res_t expected_q[$];

    function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic frac_res_t solve_fraction(logic [InBits-1:0] w);
        logic [2:0] act;
        longint     ln, ld, rn, rd, num, den, a, b;
        longint unsigned mag, g;
        logic       arith;
        frac_res_t  r;
        act = w[2:0];
        ln  = longint'($signed(w[18:3]));
        ld  = longint'(w[33:19]);
        rn  = longint'($signed(w[49:34]));
        rd  = longint'(w[64:50]);
        if (ld == 0) ld = 1;
        if (rd == 0) rd = 1;
        num = 0;
        den = 1;
        arith = 1'b1;
        r.num = '0;
        r.den = 31'd1;
        r.ord = ORD_EQUAL;
        r.dz  = 1'b0;
        case (act)
            ACT_ADD: begin num = ln * rd + rn * ld; den = ld * rd; end
            ACT_SUB: begin num = ln * rd - rn * ld; den = ld * rd; end
            ACT_MUL: begin num = ln * rn; den = ld * rd; end
            ACT_DIV:
            begin
                if (rn == 0)
                begin
                    r.dz = 1'b1;
                    arith = 1'b0;
                end
                else
                begin
                    num = ln * rd;
                    den = ld * rn;
                    if (den < 0)
                    begin
                        den = -den;
                        num = -num;
                    end
                end
            end
            ACT_CMP:
            begin
                a = ln * rd;
                b = rn * ld;
                r.ord = (a < b) ? ORD_LESS : ((a == b) ? ORD_EQUAL : ORD_GREATER);
                arith = 1'b0;
            end
            default: arith = 1'b0;
        endcase
        if (arith && num != 0)
        begin
            mag = (num < 0) ? longint'(-num) : longint'(num);
            g = euclid(mag, longint'(den));
            mag = mag / g;
            num = (num < 0) ? -longint'(mag) : longint'(mag);
            r.num = num[31:0];
            r.den = 31'(longint'(den) / longint'(g));
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frac_res_t e, got;
        if (!rst_n)
        begin
            fail_count <= 0;
            checked <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(solve_fraction(s_axis_tdata[InBits-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.num = m_axis_tdata[31:0];
                got.den = m_axis_tdata[62:32];
                got.ord = m_axis_tdata[64:63];
                got.dz  = m_axis_tdata[65];
                checked <= checked + 1;
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e != got)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp num %0d den %0d ord %0d dz %0d, got num %0d den %0d ord %0d dz %0d",
                                $signed(e.num), e.den, e.ord, e.dz,
                                $signed(got.num), got.den, got.ord, got.dz);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // outstanding items after this edge's accept and result
            pending <= expected_q.size();
        end
    end
endmodule

### test/tb.sv
// Testbench top: stimulus, output stalls and the verdict for the rational arithmetic unit.
`timescale 1ns / 100ps
module tb;
    import rau_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [8*InBytes-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [8*OutBytes-1:0] m_axis_tdata;
    int   fail_count, pending, checked;
    bit   long_hold = 1'b0;
    int   sent = 0;

    always #2 clk = ~clk;

    rational_arithmetic_unit dut (.*);

    rau_scoreboard chk (.*);

    function automatic logic [InBits-1:0] pack_item(logic [2:0] act, logic [15:0] ln,
        logic [14:0] ld, logic [15:0] rn, logic [14:0] rd);
        return {rd, rn, ld, ln, act};
    endfunction

    function automatic logic [15:0] pick_num();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_den();
        case ($urandom_range(0, 5))
            0: return 15'h7fff;
            1: return 15'd1;
            2: return 15'd0;
            3: return 15'($urandom_range(1, 30));
            default: return 15'($urandom);
        endcase
    endfunction

    task automatic send_fraction(logic [InBits-1:0] w);
        s_axis_tdata <= {{(8*InBytes-InBits){1'b0}}, w};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 300))
            @(posedge clk);
    endtask

    // receiver: random stall pattern, with a long hold-off when asked
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
                m_axis_tready <= 1'b0;
            else if (($urandom_range(0, 1000) / 100) % 2 == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        #40_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        int burst, wait_cyc;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, every action, zero denominators, zero divisor, bad codes
        for (int a = 0; a < 8; a++)
        begin
            send_fraction(pack_item(3'(a), 16'h8000, 15'h7fff, 16'h7fff, 15'd1));
            send_fraction(pack_item(3'(a), 16'h7fff, 15'd0, 16'h8000, 15'h7fff));
        end
        send_fraction(pack_item(ACT_DIV, 16'd5, 15'd3, 16'd0, 15'd7));
        send_fraction(pack_item(ACT_DIV, 16'd3, 15'd4, 16'hfffe, 15'd3));
        send_fraction(pack_item(ACT_SUB, 16'd2, 15'd6, 16'd1, 15'd3));
        send_fraction(pack_item(ACT_CMP, 16'd1, 15'd2, 16'd2, 15'd4));
        send_fraction(pack_item(ACT_CMP, 16'hffff, 15'd2, 16'd1, 15'd3));
        send_fraction(pack_item(ACT_MUL, 16'h8000, 15'd1, 16'h8000, 15'd1));
        s_axis_tvalid <= 1'b0;
        // sender pauses until every outstanding result is back
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                long_hold = 1'b1;
                repeat (3000) @(posedge clk);
                long_hold = 1'b0;
            end
            repeat (6)
                send_fraction(pack_item(3'($urandom_range(0, 4)), pick_num(), pick_den(),
                    pick_num(), pick_den()));
        join
        while (sent < 1120)
        begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++)
                send_fraction(pack_item(($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                    : 3'($urandom_range(0, 4)), pick_num(), pick_den(), pick_num(),
                    pick_den()));
            if ($urandom_range(0, 2) != 0)
                drop_valid();
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        wait_cyc = 0;
        while (wait_cyc < 2000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        $display("tb: %0d items sent, %0d results checked over all actions, bad codes and edge values",
            sent, checked);
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
